// ===== rtl/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants of the I2C character LCD nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 7;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BITPOS_W = 4;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BYTE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NIBBLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK    = 2'd2;

    localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd39;
    localparam logic [BYTE_W-1:0] BACKLIGHT_MASK_RST = 8'h08;
    localparam logic [BYTE_W-1:0] ENABLE_MASK_RST    = 8'h04;

    localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'hF0;

    localparam logic [1:0] FRAME_ADDR   = 2'd0;
    localparam logic [1:0] FRAME_ENABLE = 2'd1;
    localparam logic [1:0] FRAME_DATA   = 2'd2;

    localparam logic [BITPOS_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_START_FALL = 10'b00_0000_0010,
        PH_START_SCL  = 10'b00_0000_0100,
        PH_BIT_RISE   = 10'b00_0000_1000,
        PH_BIT_FALL   = 10'b00_0001_0000,
        PH_ACK_RISE   = 10'b00_0010_0000,
        PH_ACK_FALL   = 10'b00_0100_0000,
        PH_GAP        = 10'b00_1000_0000,
        PH_STOP_RISE  = 10'b01_0000_0000,
        PH_STOP_SDA   = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] data_byte;
        logic              reg_select;
        logic              sda_in;
    } item_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic sda_drive;
        logic busy_res;
        logic nack_seen;
        logic request_done;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [BYTE_W-1:0] backlight_mask;
        logic [BYTE_W-1:0] enable_mask;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lcdw_if.sv =====
// ----------------------------------------------------------------------------
// lcdw channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdw_item_if import lcdw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] data_byte;
    logic              reg_select;
    logic              sda_in;

    modport source (output valid, req_type, data_byte, reg_select, sda_in, input ready);
    modport sink   (input valid, req_type, data_byte, reg_select, sda_in, output ready);
endinterface

interface lcdw_result_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic nack_seen;
    logic request_done;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, nack_seen,
                    request_done, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, nack_seen,
                    request_done, output ready);
endinterface

interface lcdw_cfg_if import lcdw_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcdw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lcdw_cfg_regs
// Configuration register file: device address, backlight and enable masks.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_cfg_regs
    import lcdw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lcdw_cfg_if.sink     cfg,
    output cfg_t         cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg.data[ADDR_W-1:0];
                CFG_BACKLIGHT_MASK: cfg_next.backlight_mask = cfg.data;
                CFG_ENABLE_MASK:    cfg_next.enable_mask    = cfg.data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.backlight_mask <= BACKLIGHT_MASK_RST;
            cfg_reg.enable_mask    <= ENABLE_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcdw_in_stage.sv =====
// ----------------------------------------------------------------------------
// lcdw_in_stage
// Input register: captures one request item, released when the engine steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_in_stage
    import lcdw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lcdw_item_if.sink  item,
    input  logic       step,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign item.ready = !valid_reg || step;
    assign load       = item.valid && item.ready;
    assign valid_next = load || (valid_reg && !step);
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.req_type   <= item.req_type;
            item_reg.data_byte  <= item.data_byte;
            item_reg.reg_select <= item.reg_select;
            item_reg.sda_in     <= item.sda_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcdw_engine.sv =====
// ----------------------------------------------------------------------------
// lcdw_engine
// Bus schedule state: one half-bit step of SCL/SDA per tick, request loading.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_engine
    import lcdw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   in_item,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t              phase_reg,   phase_next;
    logic [BITPOS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [1:0]          frame_reg,   frame_next;
    logic                second_reg,  second_next;
    logic [BYTE_W-1:0]   shift_reg,   shift_next;
    logic [BYTE_W-1:0]   held_reg,    held_next;
    logic                rs_reg,      rs_next;
    logic                nack_reg,    nack_next;
    logic                scl_reg,     scl_next;
    logic                sda_reg,     sda_next;
    logic                done;
    logic [BYTE_W-1:0]   expander;
    logic [BITPOS_W-1:0] bit_inc;

    assign expander = (held_reg & NIBBLE_MASK) | {{(BYTE_W-1){1'b0}}, rs_reg}
                      | cfg.backlight_mask;
    assign bit_inc  = bit_pos_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        frame_next   = frame_reg;
        second_next  = second_reg;
        shift_next   = shift_reg;
        held_next    = held_reg;
        rs_next      = rs_reg;
        nack_next    = nack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done         = 1'b0;

        if (step)
        begin
            unique case (in_item.req_type) inside
                REQ_TICK:
                begin
                    unique case (phase_reg)
                        PH_IDLE: ;
                        PH_START_FALL:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_START_SCL;
                        end
                        PH_START_SCL:
                        begin
                            scl_next     = 1'b0;
                            shift_next   = {cfg.device_address, 1'b0};
                            frame_next   = FRAME_ADDR;
                            bit_pos_next = '0;
                            phase_next   = PH_BIT_RISE;
                        end
                        PH_BIT_RISE:
                        begin
                            sda_next   = shift_reg[BYTE_W-1];
                            scl_next   = 1'b1;
                            phase_next = PH_BIT_FALL;
                        end
                        PH_BIT_FALL:
                        begin
                            scl_next     = 1'b0;
                            shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
                            bit_pos_next = bit_inc;
                            phase_next   = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_RISE
                                                                      : PH_BIT_RISE;
                        end
                        PH_ACK_RISE:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_ACK_FALL;
                        end
                        PH_ACK_FALL:
                        begin
                            scl_next = 1'b0;
                            if (in_item.sda_in)
                            begin
                                nack_next  = 1'b1;
                                sda_next   = 1'b0;
                                phase_next = PH_STOP_RISE;
                            end
                            else if (frame_reg == FRAME_ADDR)
                            begin
                                shift_next   = expander | cfg.enable_mask;
                                frame_next   = FRAME_ENABLE;
                                bit_pos_next = '0;
                                phase_next   = PH_BIT_RISE;
                            end
                            else if (frame_reg == FRAME_ENABLE)
                            begin
                                phase_next = PH_GAP;
                            end
                            else
                            begin
                                sda_next   = 1'b0;
                                phase_next = PH_STOP_RISE;
                            end
                        end
                        PH_GAP:
                        begin
                            shift_next   = expander;
                            frame_next   = FRAME_DATA;
                            bit_pos_next = '0;
                            phase_next   = PH_BIT_RISE;
                        end
                        PH_STOP_RISE:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_STOP_SDA;
                        end
                        PH_STOP_SDA:
                        begin
                            sda_next = 1'b1;
                            if (second_reg)
                            begin
                                second_next = 1'b0;
                                held_next   = {held_reg[BYTE_W-5:0], 4'b0000};
                                phase_next  = PH_START_FALL;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                REQ_BYTE, REQ_NIBBLE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        held_next    = in_item.data_byte;
                        rs_next      = in_item.reg_select;
                        second_next  = (in_item.req_type == REQ_BYTE);
                        nack_next    = 1'b0;
                        bit_pos_next = '0;
                        frame_next   = FRAME_ADDR;
                        phase_next   = PH_START_FALL;
                    end
                end
                default: ;
            endcase
        end
    end

    assign res.scl_level    = scl_next;
    assign res.sda_level    = sda_next;
    assign res.sda_drive    = (phase_next != PH_ACK_FALL);
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.nack_seen    = nack_next;
    assign res.request_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_pos_reg <= '0;
            frame_reg   <= FRAME_ADDR;
            second_reg  <= 1'b0;
            shift_reg   <= '0;
            held_reg    <= '0;
            rs_reg      <= 1'b0;
            nack_reg    <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            frame_reg   <= frame_next;
            second_reg  <= second_next;
            shift_reg   <= shift_next;
            held_reg    <= held_next;
            rs_reg      <= rs_next;
            nack_reg    <= nack_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcdw_out_stage.sv =====
// ----------------------------------------------------------------------------
// lcdw_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_out_stage
    import lcdw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          held_valid,
    input  result_t       res,
    lcdw_result_if.source result,
    output logic          step
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign step       = held_valid && (!valid_reg || result.ready);
    assign valid_next = step || (valid_reg && !result.ready);

    assign result.valid        = valid_reg;
    assign result.scl_level    = res_reg.scl_level;
    assign result.sda_level    = res_reg.sda_level;
    assign result.sda_drive    = res_reg.sda_drive;
    assign result.busy_res     = res_reg.busy_res;
    assign result.nack_seen    = res_reg.nack_seen;
    assign result.request_done = res_reg.request_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// i2c_lcd_nibble_writer
// Write-only I2C master for a 4-bit character LCD behind a port expander.
// ----------------------------------------------------------------------------
// Each item (tick or send request) yields exactly one result holding the bus
// levels after that item. Items pass an input register, combinational
// schedule logic and a result register; one item is taken every cycle while
// results are drained. Send requests made while busy are ignored.
// Register writes are taken at any time and always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_lcd_nibble_writer
    import lcdw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcdw_item_if.sink     item,
    lcdw_result_if.source result,
    lcdw_cfg_if.sink      cfg
);

    cfg_t    cfg_val;
    logic    step;
    logic    held_valid;
    item_t   held_item;
    result_t res;

    lcdw_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    lcdw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .step       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    lcdw_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_item (held_item),
        .cfg     (cfg_val),
        .res     (res)
    );

    lcdw_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .res        (res),
        .result     (result),
        .step       (step)
    );

endmodule

`default_nettype wire

// ===== rtl/lcdw_checker.sv =====
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks of the nibble writer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_checker (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input logic scl_level,
    input logic sda_level,
    input logic sda_drive,
    input logic busy_res,
    input logic request_done
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && request_done |-> !busy_res && scl_level && sda_level)
        else $error("done without idle bus");

    a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> scl_level && sda_level)
        else $error("bus not released while idle");

    a_ack_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !sda_drive |-> busy_res && scl_level)
        else $error("SDA released outside ack clock");

endmodule

bind i2c_lcd_nibble_writer lcdw_checker u_lcdw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .scl_level    (result.scl_level),
    .sda_level    (result.sda_level),
    .sda_drive    (result.sda_drive),
    .busy_res     (result.busy_res),
    .request_done (result.request_done)
);

`default_nettype wire

// ===== tb/sv/lcd_bus_checker.sv =====
// ----------------------------------------------------------------------------
// lcd_bus_checker
// Watches the request, result and register channels of the LCD nibble writer.
// Keeps its own copy of the bus schedule and compares each result field by
// field with the oldest predicted bus levels.
// ----------------------------------------------------------------------------
module lcd_bus_checker (
    input  logic   clk,
    input  logic   rst_n,
    lcdw_item_if   item,
    lcdw_result_if result,
    lcdw_cfg_if    cfg,
    output int     fail_count,
    output int     pending,
    output logic   bus_busy
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcdw_pkg::*;

    logic [ADDR_W-1:0]   dev_addr;
    logic [BYTE_W-1:0]   bl_mask;
    logic [BYTE_W-1:0]   en_mask;

    phase_t              ph;
    logic [BITPOS_W-1:0] bit_pos;
    logic [1:0]          frame;
    logic                second_pending;
    logic [BYTE_W-1:0]   shreg;
    logic [BYTE_W-1:0]   held_byte;
    logic                held_rs;
    logic                nack_flag;
    logic                scl_r;
    logic                sda_r;

    result_t             expected_levels[$];

    function automatic logic [BYTE_W-1:0] expander_byte();
        return (held_byte & NIBBLE_MASK) | {{(BYTE_W-1){1'b0}}, held_rs} | bl_mask;
    endfunction

    function automatic void load_byte(input logic [BYTE_W-1:0] value, input logic [1:0] which);
        shreg   = value;
        frame   = which;
        bit_pos = '0;
        ph      = PH_BIT_RISE;
    endfunction

    function automatic logic advance_half_bit(input logic sda_sample);
        logic finished;
        finished = 1'b0;
        case (ph)
            PH_START_FALL:
            begin
                sda_r = 1'b0;
                ph    = PH_START_SCL;
            end
            PH_START_SCL:
            begin
                scl_r = 1'b0;
                load_byte({dev_addr, 1'b0}, FRAME_ADDR);
            end
            PH_BIT_RISE:
            begin
                sda_r = shreg[BYTE_W-1];
                scl_r = 1'b1;
                ph    = PH_BIT_FALL;
            end
            PH_BIT_FALL:
            begin
                scl_r   = 1'b0;
                shreg   = shreg << 1;
                bit_pos = bit_pos + 1'b1;
                ph      = (bit_pos >= BITS_PER_BYTE) ? PH_ACK_RISE : PH_BIT_RISE;
            end
            PH_ACK_RISE:
            begin
                scl_r = 1'b1;
                ph    = PH_ACK_FALL;
            end
            PH_ACK_FALL:
            begin
                scl_r = 1'b0;
                if (sda_sample)
                begin
                    nack_flag = 1'b1;
                    sda_r     = 1'b0;
                    ph        = PH_STOP_RISE;
                end
                else if (frame == FRAME_ADDR)
                    load_byte(expander_byte() | en_mask, FRAME_ENABLE);
                else if (frame == FRAME_ENABLE)
                    ph = PH_GAP;
                else
                begin
                    sda_r = 1'b0;
                    ph    = PH_STOP_RISE;
                end
            end
            PH_GAP:
                load_byte(expander_byte(), FRAME_DATA);
            PH_STOP_RISE:
            begin
                scl_r = 1'b1;
                ph    = PH_STOP_SDA;
            end
            PH_STOP_SDA:
            begin
                sda_r = 1'b1;
                if (second_pending)
                begin
                    second_pending = 1'b0;
                    held_byte      = held_byte << 4;
                    ph             = PH_START_FALL;
                end
                else
                begin
                    ph       = PH_IDLE;
                    finished = 1'b1;
                end
            end
            default:
                ph = PH_IDLE;
        endcase
        return finished;
    endfunction

    function automatic result_t predict_bus_levels(input item_t it);
        result_t lv;
        logic    finished;
        finished = 1'b0;
        if (it.req_type == REQ_TICK)
        begin
            if (ph != PH_IDLE)
                finished = advance_half_bit(it.sda_in);
        end
        else if ((it.req_type == REQ_BYTE || it.req_type == REQ_NIBBLE) && ph == PH_IDLE)
        begin
            held_byte      = it.data_byte;
            held_rs        = it.reg_select;
            second_pending = (it.req_type == REQ_BYTE);
            nack_flag      = 1'b0;
            bit_pos        = '0;
            frame          = FRAME_ADDR;
            ph             = PH_START_FALL;
        end
        lv.scl_level    = scl_r;
        lv.sda_level    = sda_r;
        lv.sda_drive    = (ph != PH_ACK_FALL);
        lv.busy_res     = (ph != PH_IDLE);
        lv.nack_seen    = nack_flag;
        lv.request_done = finished;
        return lv;
    endfunction

    function automatic void check_bit(input string field, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t   seen;
        result_t want;
        if (!rst_n)
        begin
            dev_addr       = DEVICE_ADDRESS_RST;
            bl_mask        = BACKLIGHT_MASK_RST;
            en_mask        = ENABLE_MASK_RST;
            ph             = PH_IDLE;
            bit_pos        = '0;
            frame          = FRAME_ADDR;
            second_pending = 1'b0;
            shreg          = '0;
            held_byte      = '0;
            held_rs        = 1'b0;
            nack_flag      = 1'b0;
            scl_r          = 1'b1;
            sda_r          = 1'b1;
            fail_count     = 0;
            expected_levels.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_DEVICE_ADDRESS: dev_addr = cfg.data[ADDR_W-1:0];
                    CFG_BACKLIGHT_MASK: bl_mask  = cfg.data;
                    CFG_ENABLE_MASK:    en_mask  = cfg.data;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                seen.req_type   = item.req_type;
                seen.data_byte  = item.data_byte;
                seen.reg_select = item.reg_select;
                seen.sda_in     = item.sda_in;
                expected_levels.push_back(predict_bus_levels(seen));
            end
            if (result.valid && result.ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("result transaction with no expected bus levels");
                    fail_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    check_bit("scl_level", want.scl_level, result.scl_level);
                    check_bit("sda_level", want.sda_level, result.sda_level);
                    check_bit("sda_drive", want.sda_drive, result.sda_drive);
                    check_bit("busy_res", want.busy_res, result.busy_res);
                    check_bit("nack_seen", want.nack_seen, result.nack_seen);
                    check_bit("request_done", want.request_done, result.request_done);
                end
            end
        end
        pending  <= expected_levels.size();
        bus_busy <= (ph != PH_IDLE);
    end

endmodule

// ===== tb/sv/tb_i2c_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_lcd_nibble_writer
// Drives send requests and half-bit ticks into the LCD nibble writer under
// several register settings, with random ACK/NACK patterns and random stalls
// on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_i2c_lcd_nibble_writer;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT    = 1000;
    localparam int SQUEEZE_CYCLES = 60;
    localparam int SETTING_ITEMS  = 330;
    localparam int NUM_SETTINGS   = 5;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    logic bus_busy;

    int   sender_idle_pct = 0;
    int   sink_idle_pct   = 0;
    bit   calm            = 1'b0;
    bit   squeeze         = 1'b0;
    int   items_sent      = 0;
    int   requests_sent   = 0;
    int   settings_used   = 1;
    int   quiet_cycles    = 0;

    lcdw_item_if   item_ch ();
    lcdw_result_if res_ch ();
    lcdw_cfg_if    cfg_ch ();

    i2c_lcd_nibble_writer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    lcd_bus_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .bus_busy   (bus_busy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] data,
                             input logic rs, input logic sda);
        if (!calm && $urandom_range(0, 99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.req_type   <= req;
        item_ch.data_byte  <= data;
        item_ch.reg_select <= rs;
        item_ch.sda_in     <= sda;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick(input logic sda);
        send_item(REQ_TICK, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
    endtask

    // 0: always ACK, 1: rare NACK/noise, 2: coin flip
    function automatic logic pick_sda(input int ack_style);
        case (ack_style)
            0:       return 1'b0;
            1:       return ($urandom_range(0, 24) == 0);
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic program_regs(input logic [BYTE_W-1:0] addr_val,
                                input logic [BYTE_W-1:0] bl_val,
                                input logic [BYTE_W-1:0] en_val);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [BYTE_W-1:0]    val [3];
        idx = '{CFG_DEVICE_ADDRESS, CFG_BACKLIGHT_MASK, CFG_ENABLE_MASK};
        val = '{addr_val, bl_val, en_val};
        for (int k = 0; k < 3; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= val[k];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // bus_busy lags one transaction, so a finished request costs one extra idle tick
    task automatic settle();
        do
        begin
            while (bus_busy)
                send_tick(1'b0);
            item_ch.valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
        while (bus_busy);
    endtask

    task automatic run_random(input int quota);
        int               count;
        int               ack_style;
        int               pick;
        logic [REQ_W-1:0] req;
        count = 0;
        while (count < quota)
        begin
            ack_style       = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 9) < 7 ? 1 : 2);
            sender_idle_pct = $urandom_range(0, 2) * 12;
            sink_idle_pct   = $urandom_range(0, 2) * 12;
            pick            = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(0, 1) ? REQ_TICK : REQ_UNUSED,
                              BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                req = $urandom_range(0, 1) ? REQ_BYTE : REQ_NIBBLE;
                send_item(req, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                requests_sent++;
                count++;
                if (pick == 9)
                begin
                    repeat ($urandom_range(1, 40))
                    begin
                        send_tick(pick_sda(2));
                        count++;
                    end
                end
                else
                begin
                    do
                    begin
                        if ($urandom_range(0, 29) == 0)
                            send_item($urandom_range(0, 1) ? REQ_UNUSED : req,
                                      BYTE_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)));
                        else
                        begin
                            send_tick(pick_sda(ack_style));
                            count++;
                        end
                    end
                    while (bus_busy);
                end
            end
        end
    endtask

    initial
    begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze)
            begin
                squeeze = 1'b0;
                hold    = SQUEEZE_CYCLES;
            end
            else if (hold == 0 && !calm && $urandom_range(0, 99) < sink_idle_pct)
                hold = $urandom_range(1, 11);
            res_ch.ready <= (hold == 0);
            if (hold > 0)
                hold--;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("i2c_lcd_nibble_writer: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.req_type   <= REQ_TICK;
        item_ch.data_byte  <= '0;
        item_ch.reg_select <= 1'b0;
        item_ch.sda_in     <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_DEVICE_ADDRESS;
        cfg_ch.data        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, unused selector, nibble with requests ignored while busy, NACK on address
        send_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
        send_item(REQ_UNUSED, 8'h00, 1'b0, 1'b1);
        send_item(REQ_NIBBLE, 8'hFF, 1'b1, 1'b0);
        send_item(REQ_BYTE, 8'h00, 1'b0, 1'b0);
        send_item(REQ_UNUSED, 8'hFF, 1'b1, 1'b0);
        repeat (22) send_tick(1'b1);
        requests_sent++;
        settle();

        for (int setting = 0; setting < NUM_SETTINGS; setting++)
        begin
            case (setting) inside
                1:       program_regs(8'h00, 8'h00, 8'h00);
                2:       program_regs(8'hFF, 8'hFF, 8'hFF);
                3, 4:    program_regs(BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)));
                default: ;
            endcase
            calm    = (setting == NUM_SETTINGS - 1);
            squeeze = (setting == 2);
            run_random(SETTING_ITEMS);
            settle();
        end

        $display("Ran %0d items with %0d send requests under %0d register settings",
                 items_sent, requests_sent, settings_used);
        $display("(reset values, all-zero, all-one and random masks and addresses).");
        if (fail_count == 0 && pending == 0)
            $display("i2c_lcd_nibble_writer: match");
        else
            $display("i2c_lcd_nibble_writer: mismatch");
        $finish;
    end

endmodule

// ===== i2c_lcd_nibble_writer.f =====
rtl/lcdw_pkg.sv
rtl/lcdw_if.sv
rtl/lcdw_cfg_regs.sv
rtl/lcdw_in_stage.sv
rtl/lcdw_engine.sv
rtl/lcdw_out_stage.sv
rtl/i2c_lcd_nibble_writer.sv
rtl/lcdw_checker.sv
tb/sv/lcd_bus_checker.sv
tb/sv/tb_i2c_lcd_nibble_writer.sv
